>>> design/feedback_frame_receiver_assert.svh
// assertion macros for the feedback frame receiver checker
`ifndef FEEDBACK_FRAME_RECEIVER_ASSERT_SVH
`define FEEDBACK_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, held off during reset
`define FFR_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ffr check failed");

// next-cycle implication, held off during reset
`define FFR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ffr check failed");

// next-cycle implication that also covers the reset cycle
`define FFR_ASSERT_NEXT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ffr check failed");

`endif

>>> design/ffr_pkg.sv
package ffr_pkg;

  localparam int PAYLOAD_BYTES = 20;
  localparam int POS_W = 5;

  localparam logic [1:0] PH_HUNT = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_DATA = 2'd2;

  localparam logic [7:0] SYNC_LOW = 8'hCD;

  localparam logic [1:0] REG_SYNC_WORD = 2'd0;
  localparam logic [1:0] REG_LOW_WRAP  = 2'd1;
  localparam logic [1:0] REG_HIGH_WRAP = 2'd2;

  localparam logic [15:0] SYNC_WORD_RST = 16'hABCD;
  localparam logic [15:0] LOW_WRAP_RST  = 16'd2700;
  localparam logic [15:0] HIGH_WRAP_RST = 16'd6300;

  typedef struct packed {
    logic               update;
    logic signed [15:0] low_wrap;
    logic signed [15:0] high_wrap;
  } wrap_ctl_t;

endpackage

>>> design/ffr_wrap_track.sv
module ffr_wrap_track (
  input  logic               clk,
  input  logic               rst,
  input  ffr_pkg::wrap_ctl_t ctl,
  input  logic signed [15:0] count_now,
  output logic signed [15:0] turns_next
);
  import ffr_pkg::*;

  logic signed [15:0] previous;
  logic signed [15:0] turns;

  always_comb begin
    turns_next = turns;
    if (ctl.update) begin
      if ((count_now < ctl.low_wrap) && (previous > ctl.high_wrap)) begin
        turns_next = turns + 16'sd1;
      end else if ((count_now > ctl.high_wrap) && (previous < ctl.low_wrap)) begin
        turns_next = turns - 16'sd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous <= '0;
      turns    <= '0;
    end else if (ctl.update) begin
      previous <= count_now;
      turns    <= turns_next;
    end
  end

endmodule

>>> design/feedback_frame_receiver.sv
// feedback frame receiver: one received byte per transfer, up to one byte per cycle
// the frame result is registered: valid the cycle after the last payload byte transfer
// throughput: one byte per cycle; the single result register stalls only the last
//   byte of a frame while the previous result is still held
// reset (rst, synchronous): hunting for sync, wrap counters and config registers at defaults
module feedback_frame_receiver (
  input  logic               clk,
  input  logic               rst,
  input  logic               byte_valid,
  output logic               byte_stall,
  input  logic [7:0]         rx_byte,
  output logic               frame_valid,
  input  logic               frame_stall,
  output logic [15:0]        command_one,
  output logic [15:0]        command_two,
  output logic [15:0]        speed_right,
  output logic [15:0]        speed_left,
  output logic signed [15:0] count_right,
  output logic signed [15:0] count_left,
  output logic [15:0]        battery_level,
  output logic [15:0]        temperature,
  output logic [15:0]        led_word,
  output logic               checksum_ok,
  output logic signed [15:0] turns_right,
  output logic signed [15:0] turns_left,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [15:0]        cfg_data
);
  import ffr_pkg::*;

  logic [15:0] sync_word;
  logic [15:0] low_wrap;
  logic [15:0] high_wrap;

  logic [1:0]       phase;
  logic [1:0]       phase_next;
  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] byte_position_next;
  logic [7:0]       payload_store [PAYLOAD_BYTES];

  logic        take;
  logic        last_byte;
  logic        frame_done;
  logic        store_wr;
  logic [7:0]  last_hi;
  logic [15:0] w [10];
  logic [15:0] xsum;
  logic        sum_ok;

  wrap_ctl_t          wctl;
  logic signed [15:0] turns_right_next;
  logic signed [15:0] turns_left_next;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_word <= SYNC_WORD_RST;
      low_wrap  <= LOW_WRAP_RST;
      high_wrap <= HIGH_WRAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_SYNC_WORD: sync_word <= cfg_data;
        REG_LOW_WRAP:  low_wrap  <= cfg_data;
        REG_HIGH_WRAP: high_wrap <= cfg_data;
        default: ;
      endcase
    end
  end

  // last payload byte of the frame (or a position already past the end)
  assign last_byte = (byte_position >= POS_W'(PAYLOAD_BYTES - 1));
  // hold the closing byte only when the result register cannot drain
  assign byte_stall = (phase == PH_DATA) && last_byte && frame_valid && frame_stall;
  assign take = byte_valid && !byte_stall;
  assign frame_done = take && (phase == PH_DATA) && last_byte;
  assign store_wr = take && (phase == PH_DATA) &&
                    (byte_position < POS_W'(PAYLOAD_BYTES));

  always_comb begin
    phase_next = phase;
    byte_position_next = byte_position;
    if (take) begin
      case (phase)
        PH_HIGH: begin
          if ({rx_byte, SYNC_LOW} == sync_word) begin
            phase_next = PH_DATA;
          end else begin
            phase_next = PH_HUNT;
          end
          byte_position_next = '0;
        end
        PH_DATA: begin
          if (last_byte) begin
            phase_next = PH_HUNT;
            byte_position_next = '0;
          end else begin
            byte_position_next = byte_position + 1'b1;
          end
        end
        default: begin
          phase_next = (rx_byte == SYNC_LOW) ? PH_HIGH : PH_HUNT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_HUNT;
      byte_position <= '0;
    end else begin
      phase         <= phase_next;
      byte_position <= byte_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (store_wr) begin
      payload_store[byte_position] <= rx_byte;
    end
  end

  // the closing byte is still on the input, not yet in the store
  assign last_hi = (byte_position == POS_W'(PAYLOAD_BYTES - 1)) ?
                   rx_byte : payload_store[PAYLOAD_BYTES - 1];

  always_comb begin
    xsum = sync_word;
    for (int k = 0; k < 9; k++) begin
      w[k] = {payload_store[2*k+1], payload_store[2*k]};
      xsum = xsum ^ w[k];
    end
    w[9] = {last_hi, payload_store[PAYLOAD_BYTES - 2]};
  end

  assign sum_ok = (w[9] == xsum);

  assign wctl.update    = frame_done && sum_ok;
  assign wctl.low_wrap  = signed'(low_wrap);
  assign wctl.high_wrap = signed'(high_wrap);

  ffr_wrap_track u_track_right (
    .clk        (clk),
    .rst        (rst),
    .ctl        (wctl),
    .count_now  (signed'(w[4])),
    .turns_next (turns_right_next)
  );

  ffr_wrap_track u_track_left (
    .clk        (clk),
    .rst        (rst),
    .ctl        (wctl),
    .count_now  (signed'(w[5])),
    .turns_next (turns_left_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= 1'b0;
    end else if (frame_done) begin
      frame_valid <= 1'b1;
    end else if (!frame_stall) begin
      frame_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_done) begin
      command_one   <= w[0];
      command_two   <= w[1];
      speed_right   <= w[2];
      speed_left    <= w[3];
      count_right   <= signed'(w[4]);
      count_left    <= signed'(w[5]);
      battery_level <= w[6];
      temperature   <= w[7];
      led_word      <= w[8];
      checksum_ok   <= sum_ok;
      turns_right   <= turns_right_next;
      turns_left    <= turns_left_next;
    end
  end

endmodule

>>> design/ffr_checker.sv
`include "feedback_frame_receiver_assert.svh"

module ffr_checker (
  input logic clk,
  input logic rst,
  input logic byte_valid,
  input logic byte_stall,
  input logic frame_valid,
  input logic frame_stall
);

  // a held result stays until its transfer
  `FFR_ASSERT_NEXT(frame_hold, frame_valid && frame_stall, frame_valid)

  // no result right out of reset
  `FFR_ASSERT_NEXT_ALWAYS(reset_empty, rst, !frame_valid)

  // a new result only follows a byte transfer
  `FFR_ASSERT_IMPLY(result_from_byte, $rose(frame_valid), $past(byte_valid && !byte_stall))

  // input backpressure only while a result is blocked
  `FFR_ASSERT_IMPLY(stall_cause, byte_stall, frame_valid && frame_stall)

endmodule

bind feedback_frame_receiver ffr_checker u_ffr_checker (
  .clk         (clk),
  .rst         (rst),
  .byte_valid  (byte_valid),
  .byte_stall  (byte_stall),
  .frame_valid (frame_valid),
  .frame_stall (frame_stall)
);

>>> dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import ffr_pkg::*;

  typedef logic [11:0][15:0] frame_t;   // command_one at index 0 .. turns_left at 11
  typedef logic [9:0][15:0] words_t;    // nine data words and the checksum word

  localparam logic [1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 4;
  localparam int REPORT_LIMIT = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic byte_valid = 1'b0;
  logic byte_stall;
  logic [7:0] rx_byte = '0;
  logic frame_valid;
  logic frame_stall = 1'b0;
  logic [15:0] command_one, command_two, speed_right, speed_left;
  logic signed [15:0] count_right, count_left;
  logic [15:0] battery_level, temperature, led_word;
  logic checksum_ok;
  logic signed [15:0] turns_right, turns_left;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = REG_SYNC_WORD;
  logic [15:0] cfg_data = '0;

  feedback_frame_receiver DUT (
    .clk(clk), .rst(rst),
    .byte_valid(byte_valid), .byte_stall(byte_stall), .rx_byte(rx_byte),
    .frame_valid(frame_valid), .frame_stall(frame_stall),
    .command_one(command_one), .command_two(command_two),
    .speed_right(speed_right), .speed_left(speed_left),
    .count_right(count_right), .count_left(count_left),
    .battery_level(battery_level), .temperature(temperature), .led_word(led_word),
    .checksum_ok(checksum_ok), .turns_right(turns_right), .turns_left(turns_left),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  string field_names [12] = '{"command_one", "command_two", "speed_right", "speed_left",
                              "count_right", "count_left", "battery_level", "temperature",
                              "led_word", "checksum_ok", "turns_right", "turns_left"};

  // receiver model state
  logic [15:0] want_sync = SYNC_WORD_RST;
  logic [15:0] want_low = LOW_WRAP_RST;
  logic [15:0] want_high = HIGH_WRAP_RST;
  logic [1:0] rx_phase = PH_HUNT;
  int fill = 0;
  logic [7:0] payload_buf [PAYLOAD_BYTES];
  logic [15:0] last_count_r = '0, last_count_l = '0;
  logic [15:0] wrap_cnt_r = '0, wrap_cnt_l = '0;
  frame_t pending_frames [$];

  int errors = 0;
  int frame_bytes = 0;
  int bytes_sent = 0;
  int good_frames = 0, bad_frames = 0, wrap_steps = 0, input_stalls = 0;
  bit send_idle_en = 1'b0, recv_idle_en = 1'b0;
  int hold_req = 0, hold_left = 0, burst_left = 0;

  function automatic logic [15:0] step_wraps(logic [15:0] now, logic [15:0] prev,
                                             logic [15:0] turns);
    if ($signed(now) < $signed(want_low) && $signed(prev) > $signed(want_high)) begin
      wrap_steps++;
      return turns + 16'd1;
    end
    if ($signed(now) > $signed(want_high) && $signed(prev) < $signed(want_low)) begin
      wrap_steps++;
      return turns - 16'd1;
    end
    return turns;
  endfunction

  // advance the receiver model by one accepted byte
  function automatic void absorb_byte(logic [7:0] b);
    frame_t f;
    logic [15:0] sum;
    logic ok;
    case (rx_phase)
      PH_HIGH: begin
        rx_phase = ({b, SYNC_LOW} == want_sync) ? PH_DATA : PH_HUNT;
        fill = 0;
      end
      PH_DATA: begin
        payload_buf[fill] = b;
        fill++;
        if (fill == PAYLOAD_BYTES) begin
          rx_phase = PH_HUNT;
          fill = 0;
          sum = want_sync;
          for (int k = 0; k < 9; k++) begin
            f[k] = {payload_buf[2*k+1], payload_buf[2*k]};
            sum ^= f[k];
          end
          ok = ({payload_buf[19], payload_buf[18]} == sum);
          if (ok) begin
            wrap_cnt_r = step_wraps(f[4], last_count_r, wrap_cnt_r);
            wrap_cnt_l = step_wraps(f[5], last_count_l, wrap_cnt_l);
            last_count_r = f[4];
            last_count_l = f[5];
            good_frames++;
          end else begin
            bad_frames++;
          end
          f[9] = {15'd0, ok};
          f[10] = wrap_cnt_r;
          f[11] = wrap_cnt_l;
          pending_frames.push_back(f);
        end
      end
      default: rx_phase = (b == SYNC_LOW) ? PH_HIGH : PH_HUNT;
    endcase
  endfunction

  // valid stays high between back-to-back bytes; random idle gaps and quiesce lower it
  task automatic send_byte(logic [7:0] b);
    if (send_idle_en && $urandom_range(0, 4) == 0) begin
      byte_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    byte_valid <= 1'b1;
    rx_byte <= b;
    @(posedge clk);
    while (byte_stall) @(posedge clk);
    bytes_sent++;
    absorb_byte(b);
  endtask

  task automatic send_frame(words_t w, logic [7:0] start_high);
    send_byte(SYNC_LOW);
    send_byte(start_high);
    for (int k = 0; k < 10; k++) begin
      send_byte(w[k][7:0]);
      send_byte(w[k][15:8]);
    end
    frame_bytes += 22;
  endtask

  // encoder counts clustered around the thresholds so wraps actually happen
  function automatic logic [15:0] pick_count();
    int v;
    case ($urandom_range(0, 6))
      0: v = int'($signed(want_low)) - 1 - int'($urandom_range(0, 300));
      1: v = int'($signed(want_high)) + 1 + int'($urandom_range(0, 300));
      2: v = int'($signed(want_low));
      3: v = int'($signed(want_high));
      4: v = $urandom_range(0, 1) ? 32'h8000 : 32'h7FFF;
      default: v = $urandom_range(0, 65535);
    endcase
    return v[15:0];
  endfunction

  function automatic words_t make_words(bit good);
    words_t w;
    logic [15:0] sum, flip;
    sum = want_sync;
    for (int k = 0; k < 9; k++) begin
      if (k == 4 || k == 5) begin
        w[k] = pick_count();
      end else begin
        case ($urandom_range(0, 5))
          0: w[k] = 16'h0000;
          1: w[k] = 16'hFFFF;
          default: w[k] = 16'($urandom_range(0, 65535));
        endcase
      end
      sum ^= w[k];
    end
    flip = 16'($urandom_range(1, 65535));
    w[9] = good ? sum : sum ^ flip;
    return w;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return ($urandom_range(0, 3) == 0) ? SYNC_LOW : b;
  endfunction

  task automatic quiesce();
    byte_valid <= 1'b0;
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // cfg_valid stays high across consecutive writes; apply_setting lowers it
  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_SYNC_WORD: want_sync = val;
      REG_LOW_WRAP: want_low = val;
      REG_HIGH_WRAP: want_high = val;
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [15:0] sync, logic [15:0] low, logic [15:0] high);
    quiesce();
    write_reg(REG_SYNC_WORD, sync);
    write_reg(REG_LOW_WRAP, low);
    write_reg(REG_HIGH_WRAP, high);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_mixed(int quota);
    int stop_at, pick, n;
    logic [7:0] flip;
    stop_at = frame_bytes + quota;
    while (frame_bytes < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 72) begin
        send_frame(make_words(pick < 64), want_sync[15:8]);
      end else if (pick < 82) begin
        // wrong high byte, sometimes another sync byte that must not restart the hunt
        flip = 8'($urandom_range(1, 255));
        send_byte(SYNC_LOW);
        send_byte($urandom_range(0, 1) ? SYNC_LOW : want_sync[15:8] ^ flip);
        frame_bytes += 2;
      end else if (pick < 88) begin
        // frame cut short: what follows lands in its payload
        n = $urandom_range(1, PAYLOAD_BYTES - 1);
        send_byte(SYNC_LOW);
        send_byte(want_sync[15:8]);
        repeat (n) send_byte(noise_byte());
        frame_bytes += n + 2;
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(noise_byte());
      end
    end
  endtask

  task automatic test_directed();
    words_t w;
    logic [15:0] sum;
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    // second byte of a failed start word is not taken as a new sync byte
    send_byte(SYNC_LOW);
    send_byte(SYNC_LOW);
    send_byte(want_sync[15:8]);
    w[0] = 16'h0000; w[1] = 16'hFFFF; w[2] = 16'h00FF; w[3] = 16'hFF00;
    w[4] = 16'd7000; w[5] = 16'h8000; w[6] = 16'h7FFF; w[7] = 16'h8001;
    w[8] = 16'h5555;
    sum = want_sync;
    for (int k = 0; k < 9; k++) sum ^= w[k];
    w[9] = sum;
    send_frame(w, want_sync[15:8]);
    quiesce();
  endtask

  task automatic test_config_sweep();
    send_idle_en = 1'b1;
    recv_idle_en = 1'b1;
    run_mixed(150);
    apply_setting(16'h12CD, 16'hFF9C, 16'd100);
    run_mixed(150);
    apply_setting(16'h00CD, 16'h8000, 16'h7FFF);
    run_mixed(150);
    apply_setting(16'hFFCD, 16'h7FFF, 16'h8000);
    run_mixed(150);
    // sync low byte other than the sync byte: nothing can ever match
    apply_setting(16'h5A3C, 16'h0000, 16'h0000);
    run_mixed(80);
    quiesce();
    write_reg(REG_SPARE, 16'($urandom_range(0, 65535)));
    write_reg(REG_SYNC_WORD, 16'hCDCD);
    write_reg(REG_LOW_WRAP, 16'hB1E0);
    write_reg(REG_HIGH_WRAP, 16'd20000);
    cfg_valid <= 1'b0;
    run_mixed(150);
  endtask

  task automatic test_backpressure();
    apply_setting(SYNC_WORD_RST, LOW_WRAP_RST, HIGH_WRAP_RST);
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    hold_req = 400;
    repeat (4) send_frame(make_words(1'b1), want_sync[15:8]);
    quiesce();
  endtask

  task automatic test_full_rate();
    send_idle_en = 1'b0;
    recv_idle_en = 1'b0;
    apply_setting(16'h34CD, 16'hF000, 16'h1000);
    run_mixed(200);
    quiesce();
  endtask

  // receiver side: long hold when requested, else random stall bursts
  always @(posedge clk) begin
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (rst) begin
      frame_stall <= 1'b0;
    end else if (hold_left > 0) begin
      frame_stall <= 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      frame_stall <= 1'b1;
      burst_left--;
    end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
      frame_stall <= 1'b1;
      burst_left = $urandom_range(0, 9);
    end else begin
      frame_stall <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s expected %h got %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_frames
    frame_t got, want;
    if (!rst && byte_valid && byte_stall) input_stalls++;
    if (!rst && frame_valid && !frame_stall) begin
      got = {turns_left, turns_right, 15'd0, checksum_ok, led_word, temperature,
             battery_level, count_left, count_right, speed_left, speed_right,
             command_two, command_one};
      if (pending_frames.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: frame transfer with nothing expected", $realtime);
      end else begin
        want = pending_frames.pop_front();
        for (int k = 0; k < 12; k++) check_field(field_names[k], want[k], got[k]);
      end
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_sweep();
    test_backpressure();
    test_full_rate();
    if (pending_frames.size() != 0) begin
      errors += pending_frames.size();
      $display("%0d expected frames never arrived", pending_frames.size());
    end
    $display("sent %0d bytes over seven register settings; %0d frames (%0d good, %0d bad)",
             bytes_sent, good_frames + bad_frames, good_frames, bad_frames);
    $display("%0d wrap counter steps, %0d cycles of input held off, %0d failures",
             wrap_steps, input_stalls, errors);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("timeout with %0d frames outstanding", pending_frames.size());
    $display("CHECK FAILED");
    $finish;
  end

endmodule
